// ----- hdl/tdlv_pkg.sv -----
`timescale 1ns / 1ps
package tdlv_pkg;

  localparam int NUM_THR    = 6;
  localparam int NUM_AX     = 3;
  localparam int NUM_REGS   = 7;
  localparam int REG_W      = 48;
  localparam int IDX_W      = 8;
  localparam int FLD_W      = 16;
  localparam int MAG_W      = 34;
  localparam int NUM_W      = MAG_W + 10;
  localparam int DIV_STAGES = NUM_W;
  localparam int SQ_STAGES  = 16;
  // product, sum, divider, clamp, square root
  localparam int LANE_LAT   = 1 + 1 + DIV_STAGES + 1 + SQ_STAGES;

  // register indexes
  localparam logic [IDX_W-1:0] REG_DIR0 = 8'd0;
  localparam logic [IDX_W-1:0] REG_DRAG = 8'd6;

  localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
    48'd3535786687,
    48'd759288511,
    48'd3535744321,
    48'd759246145,
    48'd211106232532992,
    48'd211106232532992,
    48'd80514365596091
  };

  typedef struct packed {
    logic              zero;
    logic              neg;
    logic [FLD_W-1:0]  root;
  } lane_res_t;

endpackage

// ----- hdl/tdlv_thrust_if.sv -----
`timescale 1ns / 1ps
interface tdlv_thrust_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] thrust_0;
  logic signed [15:0] thrust_1;
  logic signed [15:0] thrust_2;
  logic signed [15:0] thrust_3;
  logic signed [15:0] thrust_4;
  logic signed [15:0] thrust_5;

  modport source (output valid, thrust_0, thrust_1, thrust_2, thrust_3, thrust_4,
                  thrust_5, input ready);
  modport sink (input valid, thrust_0, thrust_1, thrust_2, thrust_3, thrust_4,
                thrust_5, output ready);
endinterface

// ----- hdl/tdlv_vel_if.sv -----
`timescale 1ns / 1ps
interface tdlv_vel_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] vel_z;

  modport source (output valid, vel_x, vel_y, vel_z, input ready);
  modport sink (input valid, vel_x, vel_y, vel_z, output ready);
endinterface

// ----- hdl/tdlv_lane.sv -----
`timescale 1ns / 1ps
module tdlv_lane import tdlv_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [FLD_W-1:0] thrust [NUM_THR],
  input  logic signed [FLD_W-1:0] dir [NUM_THR],
  input  logic [FLD_W-1:0]        drag,
  output lane_res_t               res
);

  logic signed [2*FLD_W-1:0] prod [NUM_THR];
  logic signed [MAG_W:0]     sum;
  logic [MAG_W-1:0]          mag;
  logic                      neg;

  // divider pipeline: one quotient bit per stage
  logic [NUM_W-1:0] num [DIV_STAGES+1];
  logic [FLD_W-1:0] rem [DIV_STAGES+1];
  logic [NUM_W-1:0] quo [DIV_STAGES+1];
  logic             dz  [DIV_STAGES+1];
  logic             dn  [DIV_STAGES+1];
  logic [FLD_W:0]   trial [DIV_STAGES];
  logic             dge [DIV_STAGES];

  // square root pipeline: one root bit per stage
  logic [31:0]      xs [SQ_STAGES+1];
  logic [FLD_W:0]   sr [SQ_STAGES+1];
  logic [FLD_W-1:0] rt [SQ_STAGES+1];
  logic             sz [SQ_STAGES+1];
  logic             sn [SQ_STAGES+1];
  logic [FLD_W+2:0] sh [SQ_STAGES];
  logic [FLD_W+2:0] st [SQ_STAGES];
  logic             sge [SQ_STAGES];

  // products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < NUM_THR; n++) begin
        prod[n] <= thrust[n] * dir[n];
      end
    end
  end

  // sum of products and magnitude
  always_comb begin
    sum = '0;
    for (int n = 0; n < NUM_THR; n++) begin
      sum = sum + (MAG_W+1)'(prod[n]);
    end
    neg = sum[MAG_W];
    mag = neg ? MAG_W'(-sum) : MAG_W'(sum);
  end

  // restoring division stages
  always_comb begin
    for (int i = 0; i < DIV_STAGES; i++) begin
      trial[i] = {rem[i], num[i][NUM_W-1]};
      dge[i]   = (trial[i] >= {1'b0, drag});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num[0] <= {mag, 10'd0};
      rem[0] <= '0;
      quo[0] <= '0;
      dz[0]  <= (drag == '0);
      dn[0]  <= neg;
      for (int i = 0; i < DIV_STAGES; i++) begin
        num[i+1] <= {num[i][NUM_W-2:0], 1'b0};
        rem[i+1] <= dge[i] ? FLD_W'(trial[i] - {1'b0, drag}) : trial[i][FLD_W-1:0];
        quo[i+1] <= {quo[i][NUM_W-2:0], dge[i]};
        dz[i+1]  <= dz[i];
        dn[i+1]  <= dn[i];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < SQ_STAGES; j++) begin
      sh[j]  = {sr[j], xs[j][31:30]};
      st[j]  = {1'b0, rt[j], 2'b01};
      sge[j] = (sh[j] >= st[j]);
    end
  end

  // clamp quotient at 2^30, whose root already saturates, then root stages
  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= (quo[DIV_STAGES] >= (NUM_W'(1) << 30)) ? 32'h4000_0000
                                                       : {1'b0, quo[DIV_STAGES][30:0]};
      sr[0] <= '0;
      rt[0] <= '0;
      sz[0] <= dz[DIV_STAGES];
      sn[0] <= dn[DIV_STAGES];
      for (int j = 0; j < SQ_STAGES; j++) begin
        xs[j+1] <= {xs[j][29:0], 2'b00};
        sr[j+1] <= sge[j] ? (FLD_W+1)'(sh[j] - st[j]) : sh[j][FLD_W:0];
        rt[j+1] <= {rt[j][FLD_W-2:0], sge[j]};
        sz[j+1] <= sz[j];
        sn[j+1] <= sn[j];
      end
    end
  end

  assign res = '{zero: sz[SQ_STAGES], neg: sn[SQ_STAGES], root: rt[SQ_STAGES]};

endmodule

// ----- hdl/thrust_to_drag_limited_velocity_core.sv -----
`timescale 1ns / 1ps
// Steady velocity under quadratic drag from six thruster forces. Three axis lanes each
// form the body force from the configured directions, divide its magnitude by the axis
// drag and take the square root; a merge stage applies sign and saturation. One thrust
// set is accepted per cycle while the pipeline is not held; each result passes through
// the bit-per-stage divider (44 stages) and square root (16 stages). The whole pipeline
// holds while a finished result waits. Configuration writes take effect at once and
// must be made while the pipeline is empty.
module thrust_to_drag_limited_velocity_core import tdlv_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  tdlv_thrust_if.sink       src,
  tdlv_vel_if.source        res,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]  cfg_data
);

  logic [REG_W-1:0]        regs [NUM_REGS];
  logic                    en;
  logic [LANE_LAT-1:0]     vpipe;
  logic signed [FLD_W-1:0] thrust [NUM_THR];
  logic signed [FLD_W-1:0] dir [NUM_AX][NUM_THR];
  lane_res_t               lres [NUM_AX];
  logic signed [FLD_W-1:0] vel [NUM_AX];
  logic                    out_valid;
  logic signed [FLD_W-1:0] out_x, out_y, out_z;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_REGS; r++) regs[r] <= REG_RESET[r];
    end else if (cfg_we && cfg_index <= REG_DRAG) begin
      regs[cfg_index[2:0]] <= cfg_data;
    end
  end

  // pipeline advances unless a result is stuck at the output
  assign en        = !out_valid || res.ready;
  assign src.ready = en;

  assign thrust[0] = src.thrust_0;
  assign thrust[1] = src.thrust_1;
  assign thrust[2] = src.thrust_2;
  assign thrust[3] = src.thrust_3;
  assign thrust[4] = src.thrust_4;
  assign thrust[5] = src.thrust_5;

  always_comb begin
    for (int a = 0; a < NUM_AX; a++) begin
      for (int n = 0; n < NUM_THR; n++) begin
        dir[a][n] = regs[REG_DIR0[2:0] + 3'(n)][FLD_W*a +: FLD_W];
      end
    end
  end

  // axis lanes
  for (genvar a = 0; a < NUM_AX; a++) begin : g_lane
    tdlv_lane u_lane (
      .clk    (clk),
      .en     (en),
      .thrust (thrust),
      .dir    (dir[a]),
      .drag   (regs[REG_DRAG[2:0]][FLD_W*a +: FLD_W]),
      .res    (lres[a])
    );
  end

  // item valid tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LANE_LAT-2:0], src.valid};
    end
  end

  // merge: sign and saturation
  always_comb begin
    for (int a = 0; a < NUM_AX; a++) begin
      if (lres[a].zero) begin
        vel[a] = '0;
      end else if (lres[a].neg) begin
        vel[a] = -$signed(lres[a].root);
      end else if (lres[a].root[FLD_W-1]) begin
        vel[a] = 16'sh7fff;
      end else begin
        vel[a] = $signed(lres[a].root);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vpipe[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x <= vel[0];
      out_y <= vel[1];
      out_z <= vel[2];
    end
  end

  assign res.valid = out_valid;
  assign res.vel_x = out_x;
  assign res.vel_y = out_y;
  assign res.vel_z = out_z;

  // no result straight out of reset
  a_rst_idle: assert property (@(posedge clk) $past(rst) |-> !res.valid)
    else $error("result valid right after reset");

  // zero drag on the x or z axis gives zero velocity on that axis
  a_zero_drag_x: assert property (@(posedge clk) disable iff (rst)
    res.valid && regs[REG_DRAG[2:0]][15:0] == '0 |-> res.vel_x == '0)
    else $error("nonzero x velocity with zero drag");

  a_zero_drag_z: assert property (@(posedge clk) disable iff (rst)
    res.valid && regs[REG_DRAG[2:0]][47:32] == '0 |-> res.vel_z == '0)
    else $error("nonzero z velocity with zero drag");

  // item valid tracking holds while stalled, so no item is dropped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> vpipe == $past(vpipe))
    else $error("pipeline moved while stalled");

endmodule

// ----- dv/thrust_to_drag_limited_velocity_core_tb.sv -----
`timescale 1ns / 1ps
module thrust_to_drag_limited_velocity_core_tb;
  import tdlv_pkg::*;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vel_t;

  // holds the register copy and the queue of expected velocity sets
  class velocity_scoreboard;
    logic [REG_W-1:0] geom [NUM_REGS];
    vel_t pending [$];
    int errors;

    function void reset_geom();
      for (int i = 0; i < NUM_REGS; i++) geom[i] = REG_RESET[i];
      errors = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
      if (idx < NUM_REGS) geom[idx] = val;
    endfunction

    function logic signed [15:0] axis_speed(longint f_val, logic [15:0] drag);
      longint unsigned mag, quot, root;
      if (drag == 0) return 16'sd0;
      mag = (f_val < 0) ? -f_val : f_val;
      quot = (mag << 10) / drag;
      root = 0;
      // integer square root by bisection on the result bits
      for (int b = 31; b >= 0; b--) begin
        if ((root | (64'd1 << b)) * (root | (64'd1 << b)) <= quot) root |= (64'd1 << b);
      end
      if (f_val >= 0) return (root > 32767) ? 16'sd32767 : root[15:0];
      if (root > 32768) root = 32768;
      return -root[15:0];
    endfunction

    function void note_thrust(logic signed [15:0] t [NUM_THR]);
      longint f [NUM_AX];
      vel_t v;
      for (int a = 0; a < NUM_AX; a++) begin
        f[a] = 0;
        for (int n = 0; n < NUM_THR; n++)
          f[a] += longint'(t[n]) * longint'($signed(geom[n][16*a +: 16]));
      end
      v.x = axis_speed(f[0], geom[REG_DRAG][15:0]);
      v.y = axis_speed(f[1], geom[REG_DRAG][31:16]);
      v.z = axis_speed(f[2], geom[REG_DRAG][47:32]);
      pending.push_back(v);
    endfunction

    function void check_velocity(vel_t got);
      vel_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected item x=%0d y=%0d z=%0d", $time, got.x, got.y, got.z);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.x !== want.x) begin
        $display("%0t: vel_x expected %0d actual %0d", $time, want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: vel_y expected %0d actual %0d", $time, want.y, got.y);
        errors++;
      end
      if (got.z !== want.z) begin
        $display("%0t: vel_z expected %0d actual %0d", $time, want.z, got.z);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;
  int idle_pct = 31;

  tdlv_thrust_if src ();
  tdlv_vel_if res ();
  velocity_scoreboard sb = new();

  thrust_to_drag_limited_velocity_core dut (
    .clk(clk), .rst(rst), .src(src.sink), .res(res.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // run limit
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // sample accepted items at the rising edge
  always @(posedge clk) begin
    if (!rst && src.valid && src.ready) begin
      logic signed [15:0] t [NUM_THR];
      t = '{src.thrust_0, src.thrust_1, src.thrust_2, src.thrust_3, src.thrust_4,
            src.thrust_5};
      sb.note_thrust(t);
    end
    if (!rst && res.valid && res.ready) begin
      vel_t v;
      v.x = res.vel_x; v.y = res.vel_y; v.z = res.vel_z;
      sb.check_velocity(v);
    end
  end

  // random receiver stalls
  always @(negedge clk) begin
    res.ready <= ($urandom_range(99) >= idle_pct);
  end

  // valid stays high between back-to-back items and drops only when idling
  task automatic send_thrust(logic signed [15:0] t [NUM_THR]);
    while ($urandom_range(99) < idle_pct) begin
      src.valid <= 0;
      @(negedge clk);
    end
    src.valid <= 1;
    {src.thrust_0, src.thrust_1, src.thrust_2} <= {t[0], t[1], t[2]};
    {src.thrust_3, src.thrust_4, src.thrust_5} <= {t[3], t[4], t[5]};
    @(posedge clk);
    while (!src.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    src.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LANE_LAT + 10) @(negedge clk);
  endtask

  // write enable stays high across consecutive writes; callers drop it afterwards
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  function automatic logic [REG_W-1:0] rand48();
    return REG_W'({$urandom(), $urandom()});
  endfunction

  task automatic send_random(int count, int mode);
    logic signed [15:0] t [NUM_THR];
    repeat (count) begin
      foreach (t[n]) begin
        case ($urandom_range(5))
          0: t[n] = 16'sh7fff;
          1: t[n] = 16'sh8000;
          2: t[n] = '0;
          3: t[n] = 16'($urandom_range(255) - 128);
          default: t[n] = 16'($urandom());
        endcase
        if (mode == 1) t[n] = 16'($urandom());
      end
      send_thrust(t);
    end
  endtask

  // geometry used by one random phase
  task automatic set_geometry(int kind);
    for (int i = 0; i < NUM_THR; i++) begin
      case (kind)
        0: write_reg(REG_DIR0 + IDX_W'(i), rand48());
        1: write_reg(REG_DIR0 + IDX_W'(i), {3{16'h7fff}});
        2: write_reg(REG_DIR0 + IDX_W'(i), {3{16'h8000}});
        default: write_reg(REG_DIR0 + IDX_W'(i), {$urandom_range(1) ? 16'h4000 : 16'hc000,
                                                  $urandom_range(1) ? 16'h2d41 : 16'hd2bf,
                                                  16'($urandom())});
      endcase
    end
    case (kind)
      0: write_reg(REG_DRAG, rand48());
      1: write_reg(REG_DRAG, {16'h0001, 16'h0000, 16'hffff});
      2: write_reg(REG_DRAG, {16'h0000, 16'hffff, 16'h0001});
      default: write_reg(REG_DRAG, {16'($urandom_range(4096)), 16'($urandom_range(255)),
                                    16'($urandom())});
    endcase
    cfg_we <= 0;
  endtask

  initial begin
    logic signed [15:0] t [NUM_THR];
    src.valid = 0;
    {src.thrust_0, src.thrust_1, src.thrust_2} = '0;
    {src.thrust_3, src.thrust_4, src.thrust_5} = '0;
    res.ready = 0;
    sb.reset_geom();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: reset geometry, zero, extremes, single thrusters
    t = '{default: 0}; send_thrust(t);
    t = '{default: 16'sh7fff}; send_thrust(t);
    t = '{default: 16'sh8000}; send_thrust(t);
    for (int n = 0; n < NUM_THR; n++) begin
      t = '{default: 0}; t[n] = 16'sh7fff; send_thrust(t);
      t[n] = 16'sh8000; send_thrust(t);
    end
    t = '{16'sh0001, 16'shffff, 16'sh0001, 16'shffff, 16'sh5555, 16'shaaaa};
    send_thrust(t);
    drain();

    // directed: zero drag, tiny drag, ignored register index
    write_reg(REG_DRAG, {16'h0000, 16'h0001, 16'hffff});
    write_reg(IDX_W'(NUM_REGS), rand48());
    write_reg({IDX_W{1'b1}}, rand48());
    cfg_we <= 0;
    t = '{default: 16'sh7fff}; send_thrust(t);
    t = '{default: 16'sh8000}; send_thrust(t);
    t = '{16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000};
    send_thrust(t);
    drain();

    // random phases across geometries, one with no idling
    for (int ph = 0; ph < 8; ph++) begin
      set_geometry(ph % 4);
      idle_pct = (ph == 5) ? 0 : 31;
      send_random(190, ph % 2);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
